@@ rtl/core/ddo_pkg.sv @@
package ddo_pkg;

  localparam int          FRAC_BITS    = 16;
  localparam int unsigned PI_FX        = 205887;
  localparam logic [33:0] PI_Q30       = 34'd3373259426;
  localparam logic [33:0] HALF_PI_Q30  = 34'd1686629713;
  localparam logic [33:0] INV_GAIN_Q30 = 34'd652032874;

  localparam logic [2:0] REG_LEFT_GAIN     = 3'd0;
  localparam logic [2:0] REG_RIGHT_GAIN    = 3'd1;
  localparam logic [2:0] REG_INV_WIDTH     = 3'd2;
  localparam logic [2:0] REG_START_X       = 3'd3;
  localparam logic [2:0] REG_START_Y       = 3'd4;
  localparam logic [2:0] REG_START_HEADING = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_VW,
    ST_WMUL,
    ST_WSAT,
    ST_WRAP,
    ST_CORDIC,
    ST_STEP,
    ST_ROT,
    ST_POSE,
    ST_HEAD,
    ST_OUT
  } ddo_state_t;

  typedef struct packed {
    logic       start;
    logic       busy;
  } ddo_cordic_ctl_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0: t = 32'd843314857;  5'd1: t = 32'd497837829;
      5'd2: t = 32'd263043836;  5'd3: t = 32'd133525159;
      5'd4: t = 32'd67021686;   5'd5: t = 32'd33543515;
      5'd6: t = 32'd16775850;   5'd7: t = 32'd8388437;
      5'd8: t = 32'd4194282;    5'd9: t = 32'd2097149;
      5'd10: t = 32'd1048575;   5'd11: t = 32'd524287;
      5'd12: t = 32'd262143;    5'd13: t = 32'd131071;
      5'd14: t = 32'd65535;     5'd15: t = 32'd32767;
      5'd16: t = 32'd16383;     5'd17: t = 32'd8191;
      5'd18: t = 32'd4095;      5'd19: t = 32'd2047;
      5'd20: t = 32'd1023;      5'd21: t = 32'd511;
      5'd22: t = 32'd255;       5'd23: t = 32'd127;
      5'd24: t = 32'd63;        5'd25: t = 32'd31;
      5'd26: t = 32'd15;        5'd27: t = 32'd7;
      5'd28: t = 32'd3;         5'd29: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/core/ddo_cordic.sv @@
// Rotation-mode CORDIC, one micro-rotation per cycle. Input angle in
// [-pi, pi) at Q4.30 with quadrant fold; cosine and sine out at Q4.30.
module ddo_cordic #(
  parameter int STEPS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ddo_pkg::ddo_cordic_ctl_t ctl,
  input  logic signed [33:0]     angle,
  output logic                   done,
  output logic signed [33:0]     cos_q30,
  output logic signed [33:0]     sin_q30
);

  localparam int CW = $clog2(STEPS + 1);

  logic signed [33:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic               neg_r;
  logic [CW-1:0]      cnt_r;
  logic               run_r;
  logic [4:0]         idx;

  assign idx = 5'(cnt_r);

  always_comb begin
    if (z_r >= 0) begin
      x_nxt = x_r - (y_r >>> idx);
      y_nxt = y_r + (x_r >>> idx);
      z_nxt = z_r - $signed({2'b00, ddo_pkg::atan_q30(idx)});
    end else begin
      x_nxt = x_r + (y_r >>> idx);
      y_nxt = y_r - (x_r >>> idx);
      z_nxt = z_r + $signed({2'b00, ddo_pkg::atan_q30(idx)});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (ctl.start) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(STEPS - 1)) run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x_r <= $signed(ddo_pkg::INV_GAIN_Q30);
      y_r <= '0;
      if (angle > $signed(ddo_pkg::HALF_PI_Q30)) begin
        z_r <= angle - $signed(ddo_pkg::PI_Q30);
        neg_r <= 1'b1;
      end else if (angle < -$signed(ddo_pkg::HALF_PI_Q30)) begin
        z_r <= angle + $signed(ddo_pkg::PI_Q30);
        neg_r <= 1'b1;
      end else begin
        z_r <= angle;
        neg_r <= 1'b0;
      end
    end else if (run_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign done    = ctl.busy && !run_r && !ctl.start;
  assign cos_q30 = neg_r ? -x_r : x_r;
  assign sin_q30 = neg_r ? -y_r : y_r;

endmodule

@@ rtl/core/diff_drive_odometry.sv @@
// Speed command: accepted and stored in the speed registers, no result.
// Tick: result valid after the input transfer, once the block has run two CORDIC passes,
// compare-subtract modulo-2pi reductions of w and of the heading, and steps on a shared
// 34x34 multiplier; in_ready low meanwhile.
// Result register holds the pose; the next item waits until it is taken.
// Reset (synchronous, rst_n low): pose, speeds zero, gains to defaults.
module diff_drive_odometry #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic signed [15:0] in_left_speed,
  input  logic signed [15:0] in_right_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [18:0] out_pose_heading,
  output logic signed [31:0] out_half_rotation,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int FRAC_BITS = ddo_pkg::FRAC_BITS;
  localparam int PIF = int'(ddo_pkg::PI_FX);
  localparam logic signed [63:0] PI64  = 64'(PIF);
  localparam logic signed [63:0] TPI64 = 64'(2 * PIF);
  // 2*pi << 13 lifts any value down to -2^31 above zero; 14 halvings reduce it
  localparam logic signed [63:0] TPI_TOP = TPI64 <<< 13;

  ddo_pkg::ddo_state_t state_r, state_nxt;

  logic [31:0]        lgain_r, rgain_r;
  logic [30:0]        invw_r;
  logic signed [15:0] lspd_r, rspd_r;
  logic signed [31:0] px_r, py_r;
  logic signed [31:0] head_r;
  logic signed [63:0] a_r, b_r, c_r, d_r, e_r, w_r;
  logic signed [63:0] m_r;
  logic [3:0]         sub_r;
  logic               pass_r;
  logic signed [33:0] ch_r, sh_r;
  logic               ovalid_r;
  logic signed [31:0] ox_r, oy_r, ow_r;
  logic signed [18:0] oh_r;

  // shared multiplier, operands picked by step
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  assign prod = ma * mb;

  // angle wrap to [-pi,pi) by iterated compare-subtract on reduced value
  logic signed [63:0] red;
  assign red = (e_r >= m_r) ? e_r - m_r : e_r;

  logic               wrap_go;
  assign wrap_go = pass_r ? (sub_r == 4'd1) : (sub_r == 4'd15);

  ddo_pkg::ddo_cordic_ctl_t cctl;
  logic               cdone;
  logic signed [33:0] ccos, csin, cang;

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .ctl(cctl), .angle(cang),
    .done(cdone), .cos_q30(ccos), .sin_q30(csin)
  );

  // e_r holds angle + pi in [0, 2pi) when the CORDIC starts
  assign cang = 34'((e_r - PI64) <<< (30 - FRAC_BITS));
  assign in_ready  = (state_r == ddo_pkg::ST_IDLE) && !ovalid_r;
  assign cfg_ready = (state_r == ddo_pkg::ST_IDLE);
  assign out_valid = ovalid_r;
  assign out_pos_x = ox_r;
  assign out_pos_y = oy_r;
  assign out_pose_heading  = oh_r;
  assign out_half_rotation = ow_r;

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ddo_pkg::ST_IDLE:   if (in_valid && in_ready && in_operation) state_nxt = ddo_pkg::ST_DIST;
      ddo_pkg::ST_DIST:   if (sub_r == 4'd1) state_nxt = ddo_pkg::ST_VW;
      ddo_pkg::ST_VW:     state_nxt = ddo_pkg::ST_WMUL;
      ddo_pkg::ST_WMUL:   state_nxt = ddo_pkg::ST_WSAT;
      ddo_pkg::ST_WSAT:   state_nxt = ddo_pkg::ST_WRAP;
      ddo_pkg::ST_WRAP:   if (wrap_go) state_nxt = ddo_pkg::ST_CORDIC;
      ddo_pkg::ST_CORDIC: if (cdone) state_nxt = pass_r ? ddo_pkg::ST_ROT : ddo_pkg::ST_STEP;
      ddo_pkg::ST_STEP:   if (sub_r == 4'd1) state_nxt = ddo_pkg::ST_WRAP;
      ddo_pkg::ST_ROT:    if (sub_r == 4'd3) state_nxt = ddo_pkg::ST_POSE;
      ddo_pkg::ST_POSE:   state_nxt = ddo_pkg::ST_HEAD;
      ddo_pkg::ST_HEAD:   if (sub_r == 4'd13) state_nxt = ddo_pkg::ST_OUT;
      ddo_pkg::ST_OUT:    state_nxt = ddo_pkg::ST_IDLE;
      default:            state_nxt = ddo_pkg::ST_IDLE;
    endcase
  end

  // multiplier operand select and CORDIC control
  always_comb begin
    ma = '0;
    mb = '0;
    cctl.start = 1'b0;
    cctl.busy  = (state_r == ddo_pkg::ST_CORDIC);
    unique case (state_r)
      ddo_pkg::ST_DIST: begin
        ma = sub_r[0] ? 34'(rspd_r) : 34'(lspd_r);
        mb = sub_r[0] ? $signed({2'b00, rgain_r}) : $signed({2'b00, lgain_r});
      end
      ddo_pkg::ST_WMUL: begin
        ma = 34'(c_r);
        mb = $signed({3'b000, invw_r});
      end
      ddo_pkg::ST_WRAP: cctl.start = wrap_go;
      ddo_pkg::ST_STEP: begin
        ma = 34'(sub_r[0] ? -(csin >>> (30 - FRAC_BITS)) : (ccos >>> (30 - FRAC_BITS)));
        mb = 34'(d_r);
      end
      ddo_pkg::ST_ROT: begin
        ma = 34'((sub_r[0] ^ sub_r[1]) ? (csin >>> (30 - FRAC_BITS))
                                       : (ccos >>> (30 - FRAC_BITS)));
        mb = 34'(sub_r[1] ? b_r : a_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ddo_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
      lgain_r  <= 32'd1717987;
      rgain_r  <= 32'd1717987;
      invw_r   <= 31'd3276800;
      lspd_r   <= '0;
      rspd_r   <= '0;
      px_r     <= '0;
      py_r     <= '0;
      head_r   <= '0;
      sub_r    <= '0;
      pass_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid && out_ready) ovalid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ddo_pkg::REG_LEFT_GAIN:  lgain_r <= cfg_data;
          ddo_pkg::REG_RIGHT_GAIN: rgain_r <= cfg_data;
          ddo_pkg::REG_INV_WIDTH:  invw_r  <= cfg_data[30:0];
          ddo_pkg::REG_START_X:    px_r    <= cfg_data;
          ddo_pkg::REG_START_Y:    py_r    <= cfg_data;
          ddo_pkg::REG_START_HEADING: begin
            // 19-bit signed value: one fold is enough to land in range
            if ($signed(cfg_data[18:0]) >= $signed(19'(PIF)))
              head_r <= 32'($signed(cfg_data[18:0])) - 32'(2 * PIF);
            else if ($signed(cfg_data[18:0]) < -$signed(20'(PIF)))
              head_r <= 32'($signed(cfg_data[18:0])) + 32'(2 * PIF);
            else
              head_r <= 32'($signed(cfg_data[18:0]));
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready && !in_operation) begin
        lspd_r <= in_left_speed;
        rspd_r <= in_right_speed;
      end
      sub_r <= (state_nxt != state_r) ? 4'd0 : sub_r + 4'd1;
      unique case (state_r)
        ddo_pkg::ST_IDLE: pass_r <= 1'b0;
        ddo_pkg::ST_DIST:
          if (sub_r[0]) b_r <= sat32(64'(prod >>> (32 - FRAC_BITS)));
          else          a_r <= sat32(64'(prod >>> (32 - FRAC_BITS)));
        ddo_pkg::ST_VW: begin
          d_r <= (a_r + b_r) >>> 1;
          c_r <= (b_r - a_r < 0) ? a_r - b_r : b_r - a_r;
          w_r <= b_r - a_r;
        end
        ddo_pkg::ST_WMUL: c_r <= 64'(prod) >>> FRAC_BITS;
        ddo_pkg::ST_WSAT: begin
          if (w_r < 0) w_r <= (c_r > 64'sd2147483648) ? -64'sd2147483648 : -c_r;
          else         w_r <= (c_r > 64'sd2147483647) ? 64'sd2147483647 : c_r;
          e_r <= '0;
        end
        ddo_pkg::ST_WRAP: begin
          // first pass reduces w over 14 steps; second pass uses heading, already in range
          if (sub_r == 4'd0) begin
            e_r <= pass_r ? 64'(head_r) + PI64 : w_r + PI64 + TPI_TOP;
            m_r <= TPI_TOP;
          end else if (!pass_r && sub_r != 4'd15) begin
            e_r <= red;
            m_r <= m_r >>> 1;
          end
        end
        ddo_pkg::ST_STEP:
          if (sub_r[0]) b_r <= 64'(prod) >>> FRAC_BITS;
          else          a_r <= 64'(prod) >>> FRAC_BITS;
        ddo_pkg::ST_CORDIC: if (cdone && !pass_r) pass_r <= 1'b1;
        ddo_pkg::ST_ROT: begin
          unique case (sub_r[1:0])
            2'd0: c_r <= 64'(prod);
            2'd1: e_r <= 64'(prod);
            2'd2: c_r <= (c_r - 64'(prod)) >>> FRAC_BITS;
            default: e_r <= (e_r + 64'(prod)) >>> FRAC_BITS;
          endcase
        end
        ddo_pkg::ST_POSE: begin
          px_r <= px_r + c_r[31:0];
          py_r <= py_r + e_r[31:0];
          e_r  <= 64'(head_r) + w_r + PI64 + TPI_TOP;
          m_r  <= TPI_TOP;
        end
        ddo_pkg::ST_HEAD: begin
          e_r <= red;
          m_r <= m_r >>> 1;
        end
        ddo_pkg::ST_OUT: begin
          head_r   <= 32'(e_r - PI64);
          ox_r     <= px_r;
          oy_r     <= py_r;
          oh_r     <= 19'(e_r - PI64);
          ow_r     <= 32'(w_r >>> 1);
          ovalid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_no_in: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ddo_pkg::ST_IDLE) |-> !in_ready)
    else $error("input taken while busy");
  a_head_rng: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ddo_pkg::ST_IDLE) |-> ($signed(head_r) >= -$signed(32'(PIF)) &&
                                       $signed(head_r) < $signed(32'(PIF))))
    else $error("heading out of range");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ddo_pkg::ST_OUT) |=> out_valid)
    else $error("result lost");
`endif

endmodule
